[rtl/rep_pkg.sv]
`default_nettype none

package rep_pkg;

    // Width of the internal bound arithmetic; saturation happens at 2^(BOUND_WIDTH-1)-1.
    localparam int BOUND_WIDTH = 32;
    localparam int OUT_WIDTH   = 32;
    localparam int CH_WIDTH    = 16;
    localparam int DIGIT_WIDTH = 4;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef logic signed [BOUND_WIDTH-1:0] bound_t;

    localparam bound_t BOUND_MAX   = {1'b0, {(BOUND_WIDTH-1){1'b1}}};
    localparam bound_t BOUND_ZERO  = '0;
    localparam bound_t BOUND_ONE   = bound_t'(1);
    localparam bound_t BOUND_UNB   = bound_t'(-1);
    localparam bound_t BOUND_QUERY = bound_t'(-2);
    localparam bound_t BOUND_ERR   = bound_t'(-3);

    localparam logic [CH_WIDTH-1:0] CH_LT    = 16'h003C;
    localparam logic [CH_WIDTH-1:0] CH_GT    = 16'h003E;
    localparam logic [CH_WIDTH-1:0] CH_QUEST = 16'h003F;
    localparam logic [CH_WIDTH-1:0] CH_DASH  = 16'h002D;
    localparam logic [CH_WIDTH-1:0] CH_EQ    = 16'h003D;
    localparam logic [CH_WIDTH-1:0] CH_ZERO  = 16'h0030;
    localparam logic [CH_WIDTH-1:0] CH_NINE  = 16'h0039;

    typedef enum logic [2:0] {
        CLS_NONE,
        CLS_DIGIT,
        CLS_LT,
        CLS_GT,
        CLS_QUEST,
        CLS_DASH,
        CLS_EQ,
        CLS_OTHER
    } char_class_t;

    typedef struct packed {
        char_class_t            cls;
        logic [DIGIT_WIDTH-1:0] digit;
        logic                   last;
    } item_t;

    typedef enum logic [3:0] {
        PH_INIT,
        PH_NUM,
        PH_LE,
        PH_LT,
        PH_GE,
        PH_GT,
        PH_QUESTION,
        PH_RANGE,
        PH_ERR
    } phase_t;

    // Decimal accumulate v*10+d, clamped at BOUND_MAX. Negative inputs count as zero.
    function automatic bound_t accumulate(input bound_t v, input logic [DIGIT_WIDTH-1:0] d);
        logic [BOUND_WIDTH+3:0] base;
        logic [BOUND_WIDTH+3:0] prod;
        base = v[BOUND_WIDTH-1] ? '0 : {4'b0000, v};
        prod = (base << 3) + (base << 1) + {{BOUND_WIDTH{1'b0}}, d};
        if (prod > {4'b0000, BOUND_MAX})
            return BOUND_MAX;
        else
            return bound_t'(prod[BOUND_WIDTH-1:0]);
    endfunction

    // Sign-extend or truncate a bound to the output width.
    function automatic logic [OUT_WIDTH-1:0] to_out(input bound_t v);
        logic [64:0] ext;
        ext = {{(65-BOUND_WIDTH){v[BOUND_WIDTH-1]}}, v};
        return ext[OUT_WIDTH-1:0];
    endfunction

endpackage

`default_nettype wire

[rtl/rep_front.sv]
`default_nettype none

module rep_front
    import rep_pkg::*;
(
    input  wire logic [CH_WIDTH-1:0] ch,
    input  wire logic                has_char,
    input  wire logic                last,
    output item_t                    item
);

    logic [CH_WIDTH-1:0] digit_off;

    assign digit_off = ch - CH_ZERO;

    always_comb
    begin
        item.last  = last;
        item.digit = '0;
        if (!has_char)
            item.cls = CLS_NONE;
        else if (ch >= CH_ZERO && ch <= CH_NINE)
        begin
            item.cls   = CLS_DIGIT;
            item.digit = digit_off[DIGIT_WIDTH-1:0];
        end
        else if (ch == CH_LT)
            item.cls = CLS_LT;
        else if (ch == CH_GT)
            item.cls = CLS_GT;
        else if (ch == CH_QUEST)
            item.cls = CLS_QUEST;
        else if (ch == CH_DASH)
            item.cls = CLS_DASH;
        else if (ch == CH_EQ)
            item.cls = CLS_EQ;
        else
            item.cls = CLS_OTHER;
    end

endmodule

`default_nettype wire

[rtl/rep_queue.sv]
`default_nettype none

module rep_queue
    import rep_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire item_t push_item,
    output logic       full,
    input  wire logic  pop,
    output logic       head_valid,
    output item_t      head_item
);

    item_t                 entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

endmodule

`default_nettype wire

[rtl/rep_back.sv]
`default_nettype none

module rep_back
    import rep_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  head_valid,
    input  wire item_t                 head_item,
    output logic                       pop,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [OUT_WIDTH-1:0]       out_low,
    output logic [OUT_WIDTH-1:0]       out_high
);

    phase_t phase_reg, phase_next;
    bound_t first_reg, first_next;
    bound_t second_reg, second_next;
    logic   ignore_reg, ignore_next;

    logic                 out_valid_reg, out_valid_next;
    logic [OUT_WIDTH-1:0] out_low_reg, out_low_next;
    logic [OUT_WIDTH-1:0] out_high_reg, out_high_next;

    // State after the current character is applied.
    phase_t s_phase;
    bound_t s_first;
    bound_t s_second;
    logic   s_ignore;
    bound_t res_low;
    bound_t res_high;
    logic   out_free;
    logic   is_digit;

    assign out_free  = !out_valid_reg || out_ready;
    assign pop       = head_valid && (!head_item.last || out_free);
    assign out_valid = out_valid_reg;
    assign out_low   = out_low_reg;
    assign out_high  = out_high_reg;
    assign is_digit  = (head_item.cls == CLS_DIGIT);

    // Character step.
    always_comb
    begin
        s_phase  = phase_reg;
        s_first  = first_reg;
        s_second = second_reg;
        s_ignore = ignore_reg;
        if (head_item.cls != CLS_NONE && !ignore_reg)
        begin
            unique case (phase_reg)
                PH_INIT:
                begin
                    unique case (head_item.cls)
                        CLS_LT:
                        begin
                            s_first = BOUND_UNB;
                            s_phase = PH_LT;
                        end
                        CLS_GT:
                        begin
                            s_second = BOUND_UNB;
                            s_phase  = PH_GT;
                        end
                        CLS_QUEST:
                        begin
                            s_first  = BOUND_QUERY;
                            s_second = BOUND_QUERY;
                            s_phase  = PH_QUESTION;
                        end
                        CLS_DIGIT:
                        begin
                            s_phase  = PH_NUM;
                            s_second = BOUND_UNB;
                            s_first  = bound_t'(head_item.digit);
                        end
                        default:
                        begin
                            s_phase  = PH_ERR;
                            s_first  = BOUND_ERR;
                            s_second = BOUND_ERR;
                            s_ignore = 1'b1;
                        end
                    endcase
                end
                PH_LT, PH_LE:
                begin
                    priority if (head_item.cls == CLS_EQ && phase_reg == PH_LT)
                        s_phase = PH_LE;
                    else if (is_digit)
                        s_second = accumulate(second_reg, head_item.digit);
                    else
                    begin
                        s_phase  = PH_ERR;
                        s_first  = BOUND_ERR;
                        s_second = BOUND_ERR;
                        s_ignore = 1'b1;
                    end
                end
                PH_GT, PH_GE:
                begin
                    priority if (head_item.cls == CLS_EQ && phase_reg == PH_GT)
                        s_phase = PH_GE;
                    else if (is_digit)
                        s_first = accumulate(first_reg, head_item.digit);
                    else
                    begin
                        s_phase  = PH_ERR;
                        s_first  = BOUND_ERR;
                        s_second = BOUND_ERR;
                        s_ignore = 1'b1;
                    end
                end
                PH_NUM:
                begin
                    priority if (is_digit)
                        s_first = accumulate(first_reg, head_item.digit);
                    else if (head_item.cls == CLS_DASH)
                    begin
                        s_second = BOUND_ZERO;
                        s_phase  = PH_RANGE;
                    end
                    else
                        s_ignore = 1'b1;
                end
                PH_RANGE:
                begin
                    if (is_digit)
                        s_second = accumulate(second_reg, head_item.digit);
                    else
                        s_ignore = 1'b1;
                end
                default:
                    s_ignore = 1'b1;
            endcase
        end
    end

    // Final bounds from the stepped state.
    always_comb
    begin
        res_low  = s_first;
        res_high = s_second;
        unique case (s_phase)
            PH_INIT:
            begin
                res_low  = BOUND_UNB;
                res_high = BOUND_UNB;
            end
            PH_NUM:
                res_high = s_first;
            PH_LT:
                res_high = s_second - BOUND_ONE;
            PH_GT:
                res_low = (s_first < BOUND_MAX) ? s_first + BOUND_ONE : s_first;
            default:
            begin
                res_low  = s_first;
                res_high = s_second;
            end
        endcase
    end

    always_comb
    begin
        phase_next     = phase_reg;
        first_next     = first_reg;
        second_next    = second_reg;
        ignore_next    = ignore_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_low_next   = out_low_reg;
        out_high_next  = out_high_reg;
        if (pop)
        begin
            if (head_item.last)
            begin
                phase_next     = PH_INIT;
                first_next     = BOUND_ZERO;
                second_next    = BOUND_ZERO;
                ignore_next    = 1'b0;
                out_valid_next = 1'b1;
                out_low_next   = to_out(res_low);
                out_high_next  = to_out(res_high);
            end
            else
            begin
                phase_next  = s_phase;
                first_next  = s_first;
                second_next = s_second;
                ignore_next = s_ignore;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_INIT;
            first_reg     <= BOUND_ZERO;
            second_reg    <= BOUND_ZERO;
            ignore_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            first_reg     <= first_next;
            second_reg    <= second_next;
            ignore_reg    <= ignore_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_low_reg  <= out_low_next;
        out_high_reg <= out_high_next;
    end

endmodule

`default_nettype wire

[rtl/range_expression_parser_top.sv]
`default_nettype none

// Range query parser. Characters of a query such as "12", "3-40", "<=7", ">5" or "?"
// arrive one per transaction on the s_axis side, and the transaction with tlast set
// closes the query and produces one transaction on the m_axis side carrying the lower
// and upper bound as signed 32-bit values: -1 means unbounded, -2 means the query mark
// and -3 means a syntax error. A transaction with tuser low carries no character and
// only serves to close a query when tlast is set. The block takes one transaction per
// clock cycle for as long as its four-entry queue has room; the parse state machine
// behind the queue retires one character per cycle, except that a closing transaction
// waits while the output register still holds a result not yet taken. A result passes
// from the queue through the parse state machine into an output register and is held
// there until taken, while characters of the next query keep flowing into the queue.
module range_expression_parser_top
    import rep_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [CH_WIDTH-1:0]   s_axis_tdata,   // [15:0] ch
    input  wire logic                  s_axis_tuser,   // [0] has_char
    input  wire logic                  s_axis_tlast,   // last character of the query
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [2*OUT_WIDTH-1:0]     m_axis_tdata    // [31:0] low_bound, [63:32] high_bound
);

    item_t in_item;
    item_t head_item;
    logic  queue_full;
    logic  head_valid;
    logic  pop;
    logic  push;

    logic [OUT_WIDTH-1:0] low_bound;
    logic [OUT_WIDTH-1:0] high_bound;

    assign s_axis_tready = !queue_full;
    assign push          = s_axis_tvalid && !queue_full;
    assign m_axis_tdata  = {high_bound, low_bound};

    // Front end: turns each character into a class code and digit value.
    rep_front u_front (
        .ch       (s_axis_tdata),
        .has_char (s_axis_tuser),
        .last     (s_axis_tlast),
        .item     (in_item)
    );

    // Decouples the input stream from the parser so either side can stall.
    rep_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (in_item),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    // Back end: parse state machine and output register.
    rep_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_low    (low_bound),
        .out_high   (high_bound)
    );

endmodule

`default_nettype wire

[bench/range_bounds_checker.sv]
`timescale 1ns / 100ps

// Watches both stream channels of the range query parser, keeps its own parse of
// every accepted character and compares each result transaction with the oldest
// predicted pair of bounds.
module range_bounds_checker
    import rep_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    input  logic [CH_WIDTH-1:0]    s_axis_tdata,   // [15:0] ch
    input  logic                   s_axis_tuser,   // [0] has_char
    input  logic                   s_axis_tlast,   // last character of the query
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic [2*OUT_WIDTH-1:0] m_axis_tdata,   // [31:0] low_bound, [63:32] high_bound
    output int                     fail_count,
    output int                     bounds_pending,
    output int                     chars_seen,
    output int                     bounds_seen
);

    typedef struct {
        logic signed [OUT_WIDTH-1:0] low;
        logic signed [OUT_WIDTH-1:0] high;
    } range_pair_t;

    localparam longint SAT_LIMIT  = (longint'(1) << (BOUND_WIDTH - 1)) - 1;

    phase_t      qry_phase;
    longint      lo_acc;
    longint      hi_acc;
    bit          skip_rest;
    range_pair_t expected_ranges[$];
    int          errs;
    int          n_chars;
    int          n_bounds;

    function automatic void clear_query();
        qry_phase = PH_INIT;
        lo_acc    = 0;
        hi_acc    = 0;
        skip_rest = 1'b0;
    endfunction

    function automatic void syntax_error();
        qry_phase = PH_ERR;
        lo_acc    = longint'(BOUND_ERR);
        hi_acc    = longint'(BOUND_ERR);
        skip_rest = 1'b1;
    endfunction

    // Decimal shift-in of one digit, clamped at the largest positive bound.
    function automatic longint digit_push(input longint v, input longint d);
        if (v < 0)
            v = 0;
        if (v > (SAT_LIMIT - d) / 10)
            return SAT_LIMIT;
        return v * 10 + d;
    endfunction

    function automatic void consume_char(input logic [CH_WIDTH-1:0] c);
        bit     is_dig;
        longint d;
        is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
        d      = is_dig ? longint'(c - CH_ZERO) : 0;
        if (skip_rest)
            return;
        case (qry_phase)
            PH_INIT:
            begin
                if (c == CH_LT)
                begin
                    lo_acc    = longint'(BOUND_UNB);
                    qry_phase = PH_LT;
                end
                else if (c == CH_GT)
                begin
                    hi_acc    = longint'(BOUND_UNB);
                    qry_phase = PH_GT;
                end
                else if (c == CH_QUEST)
                begin
                    lo_acc    = longint'(BOUND_QUERY);
                    hi_acc    = longint'(BOUND_QUERY);
                    qry_phase = PH_QUESTION;
                end
                else if (is_dig)
                begin
                    qry_phase = PH_NUM;
                    hi_acc    = longint'(BOUND_UNB);
                    lo_acc    = d;
                end
                else
                    syntax_error();
            end
            PH_LT, PH_LE:
            begin
                if (c == CH_EQ && qry_phase == PH_LT)
                    qry_phase = PH_LE;
                else if (is_dig)
                    hi_acc = digit_push(hi_acc, d);
                else
                    syntax_error();
            end
            PH_GT, PH_GE:
            begin
                if (c == CH_EQ && qry_phase == PH_GT)
                    qry_phase = PH_GE;
                else if (is_dig)
                    lo_acc = digit_push(lo_acc, d);
                else
                    syntax_error();
            end
            PH_NUM:
            begin
                if (is_dig)
                    lo_acc = digit_push(lo_acc, d);
                else if (c == CH_DASH)
                begin
                    hi_acc    = 0;
                    qry_phase = PH_RANGE;
                end
                else
                    skip_rest = 1'b1;
            end
            PH_RANGE:
            begin
                if (is_dig)
                    hi_acc = digit_push(hi_acc, d);
                else
                    skip_rest = 1'b1;
            end
            default:
                skip_rest = 1'b1;
        endcase
    endfunction

    // Turns the parse state into the pair of bounds and starts a fresh query.
    function automatic range_pair_t close_query();
        longint      lo;
        longint      hi;
        range_pair_t r;
        lo = lo_acc;
        hi = hi_acc;
        case (qry_phase)
            PH_INIT:
            begin
                lo = longint'(BOUND_UNB);
                hi = longint'(BOUND_UNB);
            end
            PH_NUM:
                hi = lo;
            PH_LT:
                hi = hi - 1;
            PH_GT:
                if (lo < SAT_LIMIT)
                    lo = lo + 1;
            default:
                ;
        endcase
        r.low  = lo[OUT_WIDTH-1:0];
        r.high = hi[OUT_WIDTH-1:0];
        clear_query();
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        range_pair_t                 exp_pair;
        logic signed [OUT_WIDTH-1:0] got_low;
        logic signed [OUT_WIDTH-1:0] got_high;
        if (!rst_n)
        begin
            clear_query();
            expected_ranges.delete();
            errs     = 0;
            n_chars  = 0;
            n_bounds = 0;
        end
        else
        begin
            // Results are taken first so that a result can never match the
            // prediction of a query closed at the same edge.
            if (m_axis_tvalid && m_axis_tready)
            begin
                n_bounds++;
                got_low  = m_axis_tdata[OUT_WIDTH-1:0];
                got_high = m_axis_tdata[2*OUT_WIDTH-1:OUT_WIDTH];
                if (expected_ranges.size() == 0)
                begin
                    errs++;
                    $display("%0t: unexpected result transaction, expected none, actual low %0d high %0d",
                             $time, got_low, got_high);
                end
                else
                begin
                    exp_pair = expected_ranges.pop_front();
                    if (got_low !== exp_pair.low)
                    begin
                        errs++;
                        $display("%0t: low_bound mismatch, expected %0d, actual %0d",
                                 $time, exp_pair.low, got_low);
                    end
                    if (got_high !== exp_pair.high)
                    begin
                        errs++;
                        $display("%0t: high_bound mismatch, expected %0d, actual %0d",
                                 $time, exp_pair.high, got_high);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                n_chars++;
                if (s_axis_tuser)
                    consume_char(s_axis_tdata);
                if (s_axis_tlast)
                    expected_ranges.push_back(close_query());
            end
        end
        fail_count     <= errs;
        bounds_pending <= expected_ranges.size();
        chars_seen     <= n_chars;
        bounds_seen    <= n_bounds;
    end

endmodule

[bench/tb.sv]
`timescale 1ns / 100ps

// Top of the range query parser bench. This module only makes stimulus and gives
// the verdict; prediction and comparison live in range_bounds_checker, which sits
// beside the block and watches both channels.
//
// Stimulus is organized as whole queries. A short directed part walks through the
// forms the parser knows (empty query, query mark, bare operators, ranges with a
// missing upper end, bad characters, trailing text, a query closed by an empty
// transaction). The random part then sends mostly well-formed queries with random
// digits, mixed with noise characters, full 16-bit code units and trailing junk,
// in segments that switch idling on and off on either side.
module tb;
    import rep_pkg::*;

    // The longest quiet stretch of a correct run is the receiver hold-off plus a
    // few idle gaps, so a limit this large only trips on a hung block.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 120;
    localparam int RANDOM_UNITS   = 1350;
    localparam int SEGMENTS       = 6;
    localparam int DRAIN_CYCLES   = 8;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [CH_WIDTH-1:0]    s_axis_tdata;
    logic                   s_axis_tuser;
    logic                   s_axis_tlast;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [2*OUT_WIDTH-1:0] m_axis_tdata;

    int fail_count;
    int bounds_pending;
    int chars_seen;
    int bounds_seen;

    // Idling switches for each side, and the request for a long receiver hold-off.
    bit tx_idle;
    bit rx_idle;
    bit rx_hold_req;

    logic [CH_WIDTH-1:0] qtext[$];
    int                  units_sent;
    int                  queries_sent;
    int                  quiet_cycles;

    range_expression_parser_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    range_bounds_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .s_axis_tlast   (s_axis_tlast),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .fail_count     (fail_count),
        .bounds_pending (bounds_pending),
        .chars_seen     (chars_seen),
        .bounds_seen    (bounds_seen)
    );

    initial
        clk = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Offers one transaction on the input side and returns at the edge where it
    // is taken. When the next call drives at once, tvalid simply stays high.
    task automatic send_unit(input logic [CH_WIDTH-1:0] c, input logic has,
                             input logic fin);
        int gap;
        gap = tx_idle ? $urandom_range(0, 11) : 0;
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tuser  <= has;
        s_axis_tlast  <= fin;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        units_sent++;
    endtask

    // Sends the characters held in qtext as one query. The query is closed either
    // by its last character or by a transaction that carries no character; empty
    // transactions may also be sprinkled in between, with random ch bits.
    task automatic send_text(input bit empty_close, input bit blanks);
        int                  n;
        logic [CH_WIDTH-1:0] junk;
        n = qtext.size();
        for (int i = 0; i < n; i++)
        begin
            if (blanks && $urandom_range(0, 11) == 0)
            begin
                junk = CH_WIDTH'($urandom_range(0, 65535));
                send_unit(junk, 1'b0, 1'b0);
            end
            send_unit(qtext[i], 1'b1, (i == n - 1) && !empty_close);
        end
        if (empty_close || n == 0)
        begin
            junk = CH_WIDTH'($urandom_range(0, 65535));
            send_unit(junk, 1'b0, 1'b1);
        end
        queries_sent++;
    endtask

    task automatic run_text(input string s, input bit empty_close);
        qtext.delete();
        for (int i = 0; i < s.len(); i++)
            qtext.push_back({8'h00, s[i]});
        send_text(empty_close, 1'b0);
    endtask

    task automatic add_digits(input int n);
        for (int i = 0; i < n; i++)
            qtext.push_back(CH_ZERO + CH_WIDTH'($urandom_range(0, 9)));
    endtask

    // Mostly short numbers; now and then one long enough to saturate.
    function automatic int digit_count(input int min_len);
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 12);
        return $urandom_range(min_len, 4);
    endfunction

    // A character that tends to break or end a query: operators, near misses of
    // the digit range, plain digits, digits with high bits set, letters and any code unit.
    function automatic logic [CH_WIDTH-1:0] noise_char();
        logic [CH_WIDTH-1:0] c;
        logic [7:0]          hi8;
        logic [7:0]          lo8;
        case ($urandom_range(0, 6))
            0:
                c = CH_WIDTH'($urandom_range(0, 65535));
            1:
            begin
                case ($urandom_range(0, 4))
                    0:       c = CH_LT;
                    1:       c = CH_GT;
                    2:       c = CH_QUEST;
                    3:       c = CH_DASH;
                    default: c = CH_EQ;
                endcase
            end
            2:
                c = CH_ZERO + CH_WIDTH'($urandom_range(0, 9));
            3:
                c = $urandom_range(0, 1) ? CH_ZERO - 16'd1 : CH_NINE + 16'd1;
            4:
            begin
                hi8 = 8'($urandom_range(1, 255));
                lo8 = CH_ZERO[7:0] + 8'($urandom_range(0, 9));
                c   = {hi8, lo8};
            end
            default:
                c = CH_WIDTH'($urandom_range(16'h0061, 16'h007A));
        endcase
        return c;
    endfunction

    task automatic random_query();
        int kind;
        kind = $urandom_range(0, 19);
        qtext.delete();
        if (kind <= 4)
            add_digits(digit_count(1));
        else if (kind <= 8)
        begin
            add_digits(digit_count(1));
            qtext.push_back(CH_DASH);
            add_digits(digit_count(0));
        end
        else if (kind <= 14)
        begin
            qtext.push_back(kind <= 11 ? CH_LT : CH_GT);
            if ($urandom_range(0, 1))
                qtext.push_back(CH_EQ);
            add_digits(digit_count(0));
        end
        else if (kind == 15)
            qtext.push_back(CH_QUEST);
        else if (kind >= 17)
        begin
            repeat ($urandom_range(1, 5))
                qtext.push_back(noise_char());
        end
        // Trailing text, or a bad character right after an operator.
        if ($urandom_range(0, 3) == 0)
        begin
            repeat ($urandom_range(1, 3))
                qtext.push_back(noise_char());
        end
        send_text($urandom_range(0, 5) == 0, 1'b1);
    endtask

    // Stops offering and waits until every predicted result has been taken.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (bounds_pending != 0)
            @(posedge clk);
    endtask

    // Stimulus and verdict.
    initial
    begin
        int seg_end;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        s_axis_tlast  = 1'b0;
        rst_n         = 1'b0;
        tx_idle       = 1'b1;
        rx_idle       = 1'b1;
        rx_hold_req   = 1'b0;
        units_sent    = 0;
        queries_sent  = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed queries: each form and each special case once.
        run_text("", 1'b0);        // empty query, unbounded both ways
        run_text("?x", 1'b0);      // query mark, then ignored text
        run_text("<", 1'b0);       // bare operators
        run_text("<=", 1'b0);
        run_text(">", 1'b0);
        run_text(">=", 1'b0);
        run_text("7-", 1'b0);      // range with no upper end
        run_text("0-9", 1'b0);
        run_text("<a", 1'b0);      // bad character after an operator
        run_text("a", 1'b0);       // bad character at the start
        run_text("12x", 1'b0);     // trailing text after a number
        run_text("3", 1'b1);       // closed by a transaction without a character
        drain_results();

        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            tx_idle = (seg == 0) || (seg == 3) || (seg == 4);
            rx_idle = (seg == 0) || (seg == 2) || (seg == 4);
            seg_end = units_sent + RANDOM_UNITS / SEGMENTS;
            if (seg == 2 || seg == 5)
            begin
                // Back-to-back one-character queries against a stalled receiver,
                // so the queue fills and the block pushes back on its input.
                rx_hold_req = 1'b1;
                tx_idle     = 1'b0;
                repeat (30)
                begin
                    qtext.delete();
                    add_digits(1);
                    send_text(1'b0, 1'b0);
                end
                tx_idle = (seg == 2);
            end
            while (units_sent < seg_end)
                random_query();
            if (seg == 1 || seg == 3)
                drain_results();
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d queries in %0d input transactions and checked %0d results,",
                 queries_sent, chars_seen, bounds_seen);
        $display("with idle gaps, back-pressure hold-offs and full drains between segments.");
        if (fail_count == 0 && bounds_pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Receiver: a random hold-off before each result transaction while rx_idle is set, and a long
    // stall counted here whenever the stimulus asks for one.
    initial
    begin
        int wait_cycles;
        m_axis_tready = 1'b0;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (rx_hold_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                rx_hold_req = 1'b0;
            end
            wait_cycles = rx_idle ? $urandom_range(0, 11) : 0;
            if (wait_cycles != 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (wait_cycles) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
        end
    end

    // Watchdog: ends the run when no transaction moves on either side for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog: no transaction for %0d cycles at %0t", quiet_cycles, $time);
            $display("RESULT: ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

endmodule
